// ===== rtl/core/bilinear_image_scaler_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear image scaler
// Shared property forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_SCALER_TOP_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_TOP_DEFINES_SVH

// Same-cycle implication.
`define BIS_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Next-cycle implication.
`define BIS_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/core/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants and types for the bilinear image scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bis_pkg;

  localparam int SCALE_W  = 12;               // numerator/denominator width
  localparam int POS_W    = 12;               // position field width
  localparam int DIV_BPS  = 2;                // quotient bits per divider stage
  localparam int COORD_QW = 2 * POS_W;        // position * denominator
  localparam int PIX_QW   = 8;                // blended channel width
  localparam int COORD_LAT = COORD_QW / DIV_BPS;
  localparam int LERP_LAT  = 2 + PIX_QW / DIV_BPS;

  typedef struct packed {
    logic             mode;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [31:0]      pix;
  } coord_pay_t;

endpackage

// ===== rtl/core/bis_div.sv =====
// ----------------------------------------------------------------------------
// bis_div
// Pipelined restoring divider, several lanes sharing one divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bis_div #(
  parameter int LANES = 2,
  parameter int QW    = 24,
  parameter int NW    = 12,
  parameter int BPS   = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][NW-1:0]    in_hi,     // must be below divisor
  input  logic [LANES-1:0][QW-1:0]    in_lo,
  input  logic [NW-1:0]               divisor,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    quot,
  output logic [LANES-1:0][NW-1:0]    rem
);

  localparam int STAGES = QW / BPS;

  logic                     vld   [0:STAGES];
  logic [LANES-1:0][NW-1:0] rem_q [0:STAGES];
  logic [LANES-1:0][QW-1:0] lo_q  [0:STAGES];
  logic [LANES-1:0][QW-1:0] quo_q [0:STAGES];

  assign vld[0]   = in_valid;
  assign rem_q[0] = in_hi;
  assign lo_q[0]  = in_lo;
  assign quo_q[0] = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [LANES-1:0][NW-1:0] rem_n;
    logic [LANES-1:0][QW-1:0] lo_n;
    logic [LANES-1:0][QW-1:0] quo_n;

    always_comb begin
      logic [NW:0] trial;
      rem_n = rem_q[s];
      lo_n  = lo_q[s];
      quo_n = quo_q[s];
      trial = '0;
      for (int l = 0; l < LANES; l++) begin
        for (int j = 0; j < BPS; j++) begin
          trial    = {rem_n[l], lo_n[l][QW-1]};
          lo_n[l]  = {lo_n[l][QW-2:0], 1'b0};
          if (trial >= {1'b0, divisor}) begin
            rem_n[l] = NW'(trial - {1'b0, divisor});
            quo_n[l] = {quo_n[l][QW-2:0], 1'b1};
          end else begin
            rem_n[l] = trial[NW-1:0];
            quo_n[l] = {quo_n[l][QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s+1] <= rem_n;
        lo_q[s+1]  <= lo_n;
        quo_q[s+1] <= quo_n;
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign quot      = quo_q[STAGES];
  assign rem       = rem_q[STAGES];

endmodule

// ===== rtl/core/bis_lerp.sv =====
// ----------------------------------------------------------------------------
// bis_lerp
// Weighted blend (a*(num-w) + b*w) / num over several 8-bit lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bis_lerp #(
  parameter int LANES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [LANES-1:0][7:0]               in_a,
  input  logic [LANES-1:0][7:0]               in_b,
  input  logic [bis_pkg::SCALE_W-1:0]         weight,   // below num
  input  logic [bis_pkg::SCALE_W-1:0]         num,
  output logic                                out_valid,
  output logic [LANES-1:0][bis_pkg::PIX_QW-1:0] result
);

  localparam int SW     = bis_pkg::SCALE_W;
  localparam int PROD_W = 8 + SW;

  logic                         p_valid;
  logic [LANES-1:0][PROD_W-1:0] prod_a;
  logic [LANES-1:0][PROD_W-1:0] prod_b;
  logic                         s_valid;
  logic [LANES-1:0][PROD_W-1:0] sum;
  logic [LANES-1:0][SW-1:0]     sum_hi;
  logic [LANES-1:0][7:0]        sum_lo;
  logic [SW-1:0]                inv_weight;

  assign inv_weight = num - weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
      s_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        prod_a[l] <= PROD_W'(in_a[l]) * PROD_W'(inv_weight);
        prod_b[l] <= PROD_W'(in_b[l]) * PROD_W'(weight);
        sum[l]    <= prod_a[l] + prod_b[l];
      end
    end
  end

  // sum stays below 256*num, so the high part is below the divisor
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sum_hi[l] = sum[l][PROD_W-1:8];
      sum_lo[l] = sum[l][7:0];
    end
  end

  bis_div #(
    .LANES (LANES),
    .QW    (bis_pkg::PIX_QW),
    .NW    (SW),
    .BPS   (bis_pkg::DIV_BPS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_valid),
    .in_hi     (sum_hi),
    .in_lo     (sum_lo),
    .divisor   (num),
    .out_valid (out_valid),
    .quot      (result),
    .rem       ()
  );

endmodule

// ===== rtl/core/bis_bank.sv =====
// ----------------------------------------------------------------------------
// bis_bank
// One pixel bank: single address port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bis_bank #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/bilinear_image_scaler_top.sv =====
// ----------------------------------------------------------------------------
// Bilinear image scaler
// Source pixel store plus pipelined bilinear resampler, one request a cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): mode 0 writes source pixel (pos_x,pos_y)
//   with in_red..in_alpha and yields nothing; mode 1 requests destination pixel
//   (pos_x,pos_y) and yields one out_* request on the output channel.
//   Config channel (cfg_valid/cfg_ready, always ready): cfg_index selects
//   numerator, denominator, source width, source height. Write only when idle.
//   Throughput: one request per cycle while the output is not stalled, with
//   the four neighbours read together from four x/y parity banks.
//   Stalls: when a result sits in the output register and out_ready is low,
//   the whole pipeline holds (in_ready low); nothing is dropped or repeated.
//   Reset: clears valid bits and restores the registers (1, 1, 256, 256).
//   Pixel store content is undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bilinear_image_scaler_top_defines.svh"

module bilinear_image_scaler_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // request input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int SW         = bis_pkg::SCALE_W;
  localparam int QW         = bis_pkg::COORD_QW;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam logic [1:0] REG_NUMERATOR   = 2'd0;
  localparam logic [1:0] REG_DENOMINATOR = 2'd1;
  localparam logic [1:0] REG_SRC_WIDTH   = 2'd2;
  localparam logic [1:0] REG_SRC_HEIGHT  = 2'd3;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SW-1:0] scale_num;
  logic [SW-1:0] scale_den;
  logic [8:0]    src_width;
  logic [8:0]    src_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_num  <= SW'(1);
      scale_den  <= SW'(1);
      src_width  <= 9'd256;
      src_height <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUMERATOR:   scale_num  <= cfg_data;
        REG_DENOMINATOR: scale_den  <= cfg_data;
        REG_SRC_WIDTH:   src_width  <= cfg_data[8:0];
        REG_SRC_HEIGHT:  src_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Effective numerator (zero acts as one) and last valid column/row.
  logic [SW-1:0] num_eff;
  logic [XW-1:0] wm1;
  logic [YW-1:0] hm1;

  assign num_eff = (scale_num == '0) ? SW'(1) : scale_num;

  always_comb begin
    if (src_width == '0) begin
      wm1 = '0;
    end else if (32'(src_width) > MAX_WIDTH) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(32'(src_width) - 1);
    end
    if (src_height == '0) begin
      hm1 = '0;
    end else if (32'(src_height) > MAX_HEIGHT) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(32'(src_height) - 1);
    end
  end

  // --------------------------------------------------------------------------
  // Global advance: everything moves unless a result waits on a stalled sink.
  // --------------------------------------------------------------------------
  logic adv;
  logic o_valid;

  assign adv      = !o_valid || out_ready;
  assign in_ready = adv;

  // Stage A: accepted request
  logic                a_valid;
  bis_pkg::coord_pay_t a_pay;

  // Stage B: position times denominator
  logic                b_valid;
  bis_pkg::coord_pay_t b_pay;
  logic [QW-1:0]       b_tx;
  logic [QW-1:0]       b_ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pay <= '{mode: mode, pos_x: pos_x, pos_y: pos_y,
                 pix: {in_alpha, in_blue, in_green, in_red}};
      b_pay <= a_pay;
      b_tx  <= QW'(a_pay.pos_x) * QW'(scale_den);
      b_ty  <= QW'(a_pay.pos_y) * QW'(scale_den);
    end
  end

  // --------------------------------------------------------------------------
  // Coordinate divider: source position and weight for x and y together.
  // --------------------------------------------------------------------------
  logic [1:0][SW-1:0] cd_hi;
  logic [1:0][QW-1:0] cd_lo;
  logic               cd_valid;
  logic [1:0][QW-1:0] cd_quot;
  logic [1:0][SW-1:0] cd_rem;

  assign cd_hi    = '0;
  assign cd_lo[0] = b_tx;
  assign cd_lo[1] = b_ty;

  bis_div #(
    .LANES (2),
    .QW    (QW),
    .NW    (SW),
    .BPS   (bis_pkg::DIV_BPS)
  ) u_coord_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (b_valid),
    .in_hi     (cd_hi),
    .in_lo     (cd_lo),
    .divisor   (num_eff),
    .out_valid (cd_valid),
    .quot      (cd_quot),
    .rem       (cd_rem)
  );

  // request fields ride alongside the divider
  bis_pkg::coord_pay_t pay_dl [1:bis_pkg::COORD_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      pay_dl[1] <= b_pay;
      for (int k = 2; k <= bis_pkg::COORD_LAT; k++) begin
        pay_dl[k] <= pay_dl[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: edge clamp and bank addressing. Banks are split by x and y
  // parity, so the two neighbour columns (and rows) never collide; when the
  // clamp folds them together both neighbours come from the same bank.
  // --------------------------------------------------------------------------
  bis_pkg::coord_pay_t cpay;
  logic [QW-1:0]       sx;
  logic [QW-1:0]       sy;
  logic [XW-1:0]       x0, x1, wx;
  logic [YW-1:0]       y0, y1, wy;
  logic                wr_ok;
  logic [3:0]          we_n;
  logic [3:0][BANK_AW-1:0] addr_n;

  assign cpay = pay_dl[bis_pkg::COORD_LAT];
  assign sx   = cd_quot[0];
  assign sy   = cd_quot[1];

  always_comb begin
    logic [XW-1:0]      rcol;
    logic [YW-1:0]      rrow;
    logic [BANK_AW-1:0] raddr;
    logic [BANK_AW-1:0] waddr;
    x0 = (sx < QW'(wm1)) ? XW'(sx) : wm1;
    x1 = (sx < QW'(wm1)) ? XW'(sx + QW'(1)) : wm1;
    y0 = (sy < QW'(hm1)) ? YW'(sy) : hm1;
    y1 = (sy < QW'(hm1)) ? YW'(sy + QW'(1)) : hm1;
    wr_ok = !cpay.mode && (32'(cpay.pos_x) < MAX_WIDTH) &&
            (32'(cpay.pos_y) < MAX_HEIGHT);
    wx = XW'(cpay.pos_x);
    wy = YW'(cpay.pos_y);
    waddr = BANK_AW'(32'(wy >> 1) * HALF_W + 32'(wx >> 1));
    for (int b = 0; b < 4; b++) begin
      rcol  = (x0[0] == b[0]) ? x0 : x1;
      rrow  = (y0[0] == b[1]) ? y0 : y1;
      raddr = BANK_AW'(32'(rrow >> 1) * HALF_W + 32'(rcol >> 1));
      addr_n[b] = wr_ok ? waddr : raddr;
      we_n[b]   = cd_valid && wr_ok && (wx[0] == b[0]) && (wy[0] == b[1]);
    end
  end

  logic                    c_valid;   // mode-1 request in stage C
  logic [3:0]              c_we;
  logic [3:0][BANK_AW-1:0] c_addr;
  logic [31:0]             c_wdata;
  logic [3:0]              c_sel;     // {y1, y0, x1, x0} parity
  logic [SW-1:0]           c_rx;
  logic [SW-1:0]           c_ry;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      c_we    <= '0;
    end else if (adv) begin
      c_valid <= cd_valid && cpay.mode;
      c_we    <= we_n;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_addr  <= addr_n;
      c_wdata <= cpay.pix;
      c_sel   <= {y1[0], y0[0], x1[0], x0[0]};
      c_rx    <= cd_rem[0];
      c_ry    <= cd_rem[1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: bank access. Writes and reads both happen as an item leaves
  // stage C, so a request always sees every earlier write.
  // --------------------------------------------------------------------------
  logic [3:0][31:0] bank_q;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bis_bank #(
      .DEPTH (BANK_DEPTH),
      .AW    (BANK_AW)
    ) u_bank (
      .clk   (clk),
      .en    (adv),
      .we    (c_we[b]),
      .addr  (c_addr[b]),
      .wdata (c_wdata),
      .rdata (bank_q[b])
    );
  end

  logic          d_valid;
  logic [3:0]    d_sel;
  logic [SW-1:0] d_rx;
  logic [SW-1:0] d_ry;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sel <= c_sel;
      d_rx  <= c_rx;
      d_ry  <= c_ry;
    end
  end

  // neighbour routing from the parity banks
  logic [31:0] p00, p01, p10, p11;

  assign p00 = bank_q[{d_sel[2], d_sel[0]}];
  assign p01 = bank_q[{d_sel[2], d_sel[1]}];
  assign p10 = bank_q[{d_sel[3], d_sel[0]}];
  assign p11 = bank_q[{d_sel[3], d_sel[1]}];

  // --------------------------------------------------------------------------
  // Horizontal blend: lanes 0..3 top row, lanes 4..7 bottom row.
  // --------------------------------------------------------------------------
  logic [7:0][7:0] h_a, h_b;
  logic            h_valid;
  logic [7:0][7:0] h_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      h_a[c]   = p00[8*c +: 8];
      h_b[c]   = p01[8*c +: 8];
      h_a[4+c] = p10[8*c +: 8];
      h_b[4+c] = p11[8*c +: 8];
    end
  end

  bis_lerp #(
    .LANES (8)
  ) u_lerp_h (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (d_valid),
    .in_a      (h_a),
    .in_b      (h_b),
    .weight    (d_rx),
    .num       (num_eff),
    .out_valid (h_valid),
    .result    (h_q)
  );

  // vertical weight waits out the horizontal blend
  logic [SW-1:0] ry_dl [1:bis_pkg::LERP_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      ry_dl[1] <= d_ry;
      for (int k = 2; k <= bis_pkg::LERP_LAT; k++) begin
        ry_dl[k] <= ry_dl[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Vertical blend
  // --------------------------------------------------------------------------
  logic [3:0][7:0] v_a, v_b;
  logic            l2_valid;
  logic [3:0][7:0] l2_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      v_a[c] = h_q[c];
      v_b[c] = h_q[4+c];
    end
  end

  bis_lerp #(
    .LANES (4)
  ) u_lerp_v (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (h_valid),
    .in_a      (v_a),
    .in_b      (v_b),
    .weight    (ry_dl[bis_pkg::LERP_LAT]),
    .num       (num_eff),
    .out_valid (l2_valid),
    .result    (l2_q)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [3:0][7:0] o_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= l2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_pix <= l2_q;
    end
  end

  assign out_valid = o_valid;
  assign out_red   = o_pix[0];
  assign out_green = o_pix[1];
  assign out_blue  = o_pix[2];
  assign out_alpha = o_pix[3];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BIS_ASSERT_NOW(a_coord_rem_range, cd_valid, (cd_rem[0] < num_eff) && (cd_rem[1] < num_eff), "coordinate weight not below numerator")
  `BIS_ASSERT_NOW(a_single_bank_write, 1'b1, $onehot0(c_we), "more than one bank written")
  `BIS_ASSERT_NEXT(a_stall_freezes_pipe, !adv, $stable(l2_valid) && $stable(d_valid), "pipeline moved during stall")

endmodule

// ===== test/bis_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Scaler testbench codes
// Register indexes and request modes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bis_tb_pkg;

  typedef enum logic [1:0] {
    REG_NUMERATOR   = 2'd0,
    REG_DENOMINATOR = 2'd1,
    REG_WIDTH       = 2'd2,
    REG_HEIGHT      = 2'd3
  } scale_reg_e;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } req_mode_e;

endpackage

// ===== test/bilinear_image_scaler_checker.sv =====
// ----------------------------------------------------------------------------
// Scaler checker
// Mirrors the source store and registers, predicts each blended pixel and
// compares it with what leaves the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_image_scaler_checker
  import bis_tb_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        mode,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_alpha,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [31:0] pixel_store [MAX_WIDTH*MAX_HEIGHT];
  logic [11:0] numerator, denominator;
  logic [8:0]  src_width, src_height;
  logic [31:0] expected_pixels [$];

  function automatic int unsigned fit_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [31:0] scaled_pixel(int unsigned px, int unsigned py);
    int unsigned num, den, w, h, sx, sy, rx, ry, x0, x1, y0, y1, a, b, top, bot;
    logic [31:0] p00, p01, p10, p11, res;
    num = (numerator == 0) ? 1 : numerator;
    den = denominator;
    w   = fit_dim(src_width, MAX_WIDTH);
    h   = fit_dim(src_height, MAX_HEIGHT);
    sx  = (px * den) / num;
    rx  = (px * den) % num;
    sy  = (py * den) / num;
    ry  = (py * den) % num;
    x0  = (sx < w - 1) ? sx : w - 1;
    x1  = (sx + 1 < w - 1) ? sx + 1 : w - 1;
    y0  = (sy < h - 1) ? sy : h - 1;
    y1  = (sy + 1 < h - 1) ? sy + 1 : h - 1;
    p00 = pixel_store[y0*MAX_WIDTH + x0];
    p01 = pixel_store[y0*MAX_WIDTH + x1];
    p10 = pixel_store[y1*MAX_WIDTH + x0];
    p11 = pixel_store[y1*MAX_WIDTH + x1];
    for (int c = 0; c < 4; c++) begin
      a   = p00[8*c +: 8];
      b   = p01[8*c +: 8];
      top = (a * (num - rx) + b * rx) / num;
      a   = p10[8*c +: 8];
      b   = p11[8*c +: 8];
      bot = (a * (num - rx) + b * rx) / num;
      res[8*c +: 8] = 8'((top * (num - ry) + bot * ry) / num);
    end
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      numerator   <= 12'd1;
      denominator <= 12'd1;
      src_width   <= 9'd256;
      src_height  <= 9'd256;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (scale_reg_e'(cfg_index))
          REG_NUMERATOR:   numerator   <= cfg_data;
          REG_DENOMINATOR: denominator <= cfg_data;
          REG_WIDTH:       src_width   <= cfg_data[8:0];
          REG_HEIGHT:      src_height  <= cfg_data[8:0];
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with no request outstanding", $realtime);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_red   !== want[7:0])   report("red",   out_red,   want[7:0]);
          if (out_green !== want[15:8])  report("green", out_green, want[15:8]);
          if (out_blue  !== want[23:16]) report("blue",  out_blue,  want[23:16]);
          if (out_alpha !== want[31:24]) report("alpha", out_alpha, want[31:24]);
        end
      end
      if (in_valid && in_ready) begin
        if (req_mode_e'(mode) == MODE_WRITE) begin
          if (pos_x < MAX_WIDTH && pos_y < MAX_HEIGHT)
            pixel_store[pos_y*MAX_WIDTH + pos_x] = {in_alpha, in_blue, in_green, in_red};
        end else begin
          expected_pixels.push_back(scaled_pixel(pos_x, pos_y));
        end
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

// ===== test/bilinear_image_scaler_top_tb.sv =====
// ----------------------------------------------------------------------------
// Bilinear image scaler testbench
// Loads small source images under many scale settings, requests destination
// pixels with random stalls on both sides, and leaves checking to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_image_scaler_top_tb;
  import bis_tb_pkg::*;

  localparam int MAX_W      = 256;
  localparam int MAX_H      = 256;
  localparam int DRAIN      = 40;     // longer than the pipeline is deep
  localparam int IDLE_LIMIT = 5000;   // cycles with no request moving
  localparam int HOLD_LEN   = 400;    // the one long receiver hold-off
  localparam int ITEM_GOAL  = 1400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic [11:0] pos_x = '0;
  logic [11:0] pos_y = '0;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  int fail_count, pending;
  int n_reads, n_writes, n_phases;
  int idle_cycles;
  bit calm;          // no gaps on either side while set
  bit hold_request;  // asks the receiver for its long hold-off
  bit hold_done;
  int hold_left;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bilinear_image_scaler_top #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) i_dut (.*);

  bilinear_image_scaler_checker #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) i_checker (.*);

  // Receiver: random back-pressure, plus one long hold-off counted here so
  // the pipeline fills and in_ready drops while the sender keeps offering.
  always @(negedge clk) begin
    if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // Watchdog: any stretch with nothing accepted on any channel is a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One request on the input channel; called and returns at a falling edge.
  // Valid stays high straight into the next request unless a gap is drawn.
  task automatic send_request(req_mode_e m, int x, int y, logic [31:0] pix);
    if (!calm && $urandom_range(99) < 25) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_valid = 1'b1;
    mode     = m;
    pos_x    = 12'(x);
    pos_y    = 12'(y);
    {in_alpha, in_blue, in_green, in_red} = pix;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (m == MODE_READ) n_reads++;
    else if (x < MAX_W && y < MAX_H) n_writes++;
  endtask

  task automatic write_reg(scale_reg_e idx, int value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = 12'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Block is idle once every result is back and the write tail has drained.
  task automatic wait_idle();
    in_valid = 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  // New scale setting, region fully loaded, then a mix of requests,
  // rewrites and out-of-store writes (the latter are dropped by the block).
  task automatic run_phase(int num, int den, int wreg, int hreg, int n_ops);
    int w, h, sel, xr;
    w = (wreg == 0) ? 1 : (wreg > MAX_W ? MAX_W : wreg);
    h = (hreg == 0) ? 1 : (hreg > MAX_H ? MAX_H : hreg);
    wait_idle();
    write_reg(REG_NUMERATOR, num);
    write_reg(REG_DENOMINATOR, den);
    write_reg(REG_WIDTH, wreg);
    write_reg(REG_HEIGHT, hreg);
    n_phases++;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        send_request(MODE_WRITE, x, y, $urandom);
    // columns that still land inside the scaled image, roughly
    xr = (den == 0) ? 4095 : ((w + 2) * (num == 0 ? 1 : num)) / den;
    if (xr > 4095) xr = 4095;
    for (int i = 0; i < n_ops; i++) begin
      sel = $urandom_range(99);
      if (sel < 40)
        send_request(MODE_READ, $urandom_range(0, xr), $urandom_range(0, xr), $urandom);
      else if (sel < 72)
        send_request(MODE_READ, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
      else if (sel < 92)
        send_request(MODE_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1), $urandom);
      else if (sel < 96)
        send_request(MODE_WRITE, $urandom_range(MAX_W, 4095), $urandom_range(0, 4095), $urandom);
      else
        send_request(MODE_WRITE, $urandom_range(0, 4095), $urandom_range(MAX_H, 4095), $urandom);
    end
  endtask

  initial begin
    int num, den;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed, reset scale 1/1 on a 256x256 image: only the bottom-right
    // corner is loaded, so every read lands in it, the far ones by clamping.
    send_request(MODE_WRITE, 254, 254, 32'h0000_0000);
    send_request(MODE_WRITE, 255, 254, 32'hFFFF_FFFF);
    send_request(MODE_WRITE, 254, 255, 32'hFF00_FF00);
    send_request(MODE_WRITE, 255, 255, 32'h00FF_00FF);
    send_request(MODE_WRITE, 4095, 0, 32'h1234_5678);   // outside store, dropped
    send_request(MODE_WRITE, 0, 4095, 32'h8765_4321);   // outside store, dropped
    send_request(MODE_WRITE, 256, 255, 32'hDEAD_BEEF);  // just past the edge
    send_request(MODE_READ, 254, 254, '0);
    send_request(MODE_READ, 255, 254, '0);
    send_request(MODE_READ, 254, 255, '0);
    send_request(MODE_READ, 255, 255, '0);
    send_request(MODE_READ, 4095, 4095, 32'hFFFF_FFFF);
    send_request(MODE_READ, 4095, 254, '0);
    send_request(MODE_READ, 254, 4095, '0);

    // Edge settings: zero numerator, zero denominator, zero width, oversized
    // width, oversized height, largest ratios. Long hold-off lands in the
    // upscale phase, and one phase runs with no gaps at all.
    run_phase(2, 1, 5, 4, 60);
    hold_request = 1'b1;
    run_phase(7, 3, 6, 5, 120);
    calm = 1'b1;
    run_phase(1, 3, 7, 6, 80);
    calm = 1'b0;
    run_phase(0, 5, 3, 3, 40);
    run_phase(7, 0, 4, 4, 40);
    run_phase(4095, 4095, 0, 9, 40);
    run_phase(4095, 1, 2, 2, 40);
    run_phase(1, 4095, 3, 2, 40);
    run_phase(3, 2, 511, 2, 60);
    run_phase(5, 4, 1, 257, 40);

    // Random settings, small images so the loads stay cheap.
    while (n_reads + n_writes < ITEM_GOAL) begin
      num = ($urandom_range(3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 16);
      den = ($urandom_range(3) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 16);
      run_phase(num, den, $urandom_range(1, 12), $urandom_range(1, 12), 100);
    end

    wait_idle();
    $display("Covered %0d scale settings: %0d pixel loads, %0d destination pixels read",
             n_phases, n_writes, n_reads);
    $display("Including zero and oversized registers, edge clamping and a full stall");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bis_pkg.sv
rtl/core/bis_div.sv
rtl/core/bis_lerp.sv
rtl/core/bis_bank.sv
rtl/core/bilinear_image_scaler_top.sv
test/bis_tb_pkg.sv
test/bilinear_image_scaler_checker.sv
test/bilinear_image_scaler_top_tb.sv
